// ===== hw/rtl/bmt_pkg.sv =====
`timescale 1ns / 1ps
package bmt_pkg;
    localparam int REG_W = 16;
    localparam int IDX_W = 19;
    localparam int FRACTION_BITS = 8;
    localparam logic [2:0] CFG_WIDTH = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DEPTH = 3'd2;
    localparam logic [2:0] CFG_WSEG = 3'd3;
    localparam logic [2:0] CFG_HSEG = 3'd4;
    localparam logic [2:0] CFG_DSEG = 3'd5;
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_QUAD = 1'b1;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] depth;
        logic [7:0] wseg;
        logic [7:0] hseg;
        logic [7:0] dseg;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [2:0] normal_code;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [18:0] corner_a;
        logic [18:0] corner_b;
        logic [18:0] corner_c;
        logic [18:0] corner_d;
        logic range_error;
    } result_t;
endpackage

// ===== hw/rtl/bmt_divider.sv =====
`timescale 1ns / 1ps
// pipelined unsigned restoring divider, one quotient bit per stage
module bmt_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);
    logic [NUM_W:0] valid_reg;
    logic [NUM_W-1:0] quo_reg [NUM_W+1];
    logic [DEN_W-1:0] rem_reg [NUM_W+1];
    logic [DEN_W-1:0] den_reg [NUM_W+1];
    logic [TAG_W-1:0] tag_reg [NUM_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_W-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg[0] <= in_num;
        rem_reg[0] <= '0;
        den_reg[0] <= in_den;
        tag_reg[0] <= in_tag;
    end

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        assign trial = {rem_reg[s], quo_reg[s][NUM_W-1]};
        assign diff = trial - {1'b0, den_reg[s]};
        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_reg[s];
            tag_reg[s+1] <= tag_reg[s];
            if (!diff[DEN_W])
            begin
                rem_reg[s+1] <= diff[DEN_W-1:0];
                quo_reg[s+1] <= {quo_reg[s][NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= trial[DEN_W-1:0];
                quo_reg[s+1] <= {quo_reg[s][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[NUM_W];
    assign out_quo = quo_reg[NUM_W];
    assign out_tag = tag_reg[NUM_W];
endmodule

// ===== hw/rtl/bmt_front.sv =====
`timescale 1ns / 1ps
// decode face, check range, form numerators and corner indices
module bmt_front
    import bmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic        operation,
    input  logic [2:0]  face,
    input  logic [7:0]  grid_col,
    input  logic [7:0]  grid_row,
    output logic        out_valid,
    output logic [31:0] num_u,
    output logic [31:0] num_v,
    output logic [15:0] den_u,
    output logic [15:0] den_v,
    output logic [31:0] num_tu,
    output logic [31:0] num_tv,
    output logic [7:0]  tag,
    output result_t     side
);
    // stage 1 registers
    logic valid1_reg, op1_reg, bad1_reg, neg1_reg, su1_reg, sv1_reg, en1_reg;
    logic [1:0] au1_reg, av1_reg, aw1_reg;
    logic [7:0] c1_reg, r1_reg, gu1_reg, gv1_reg;
    logic [15:0] eu1_reg, ev1_reg, ew1_reg;
    logic [18:0] base1_reg;

    logic [7:0] gw, gh, gd;
    logic [7:0] gu, gv;
    logic [1:0] au, av, aw;
    logic su, sv, neg, bad;
    logic [8:0] w1, h1, d1;
    logic [18:0] aw_h, aw_d, ah_d, base;

    function automatic logic [7:0] clampseg(input logic [7:0] s);
        clampseg = (s == 8'd0) ? 8'd1 : s;
    endfunction

    function automatic logic [15:0] ext(input cfg_t c, input logic [1:0] a);
        unique case (a)
            2'd0: ext = c.width;
            2'd1: ext = c.height;
            default: ext = c.depth;
        endcase
    endfunction

    always_comb
    begin
        gw = clampseg(cfg.wseg);
        gh = clampseg(cfg.hseg);
        gd = clampseg(cfg.dseg);
        w1 = {1'b0, gw} + 9'd1;
        h1 = {1'b0, gh} + 9'd1;
        d1 = {1'b0, gd} + 9'd1;
        ah_d = {10'd0, d1} * {10'd0, h1};
        aw_d = {10'd0, w1} * {10'd0, d1};
        aw_h = {10'd0, w1} * {10'd0, h1};
        bad = 1'b0;
        gu = gw; gv = gh; au = 2'd0; av = 2'd1; aw = 2'd2;
        su = 1'b0; sv = 1'b1; neg = 1'b0; base = '0;
        unique case (face)
            3'd0: begin gu = gd; gv = gh; au = 2'd2; av = 2'd1; aw = 2'd0;
                su = 1'b1; sv = 1'b1; neg = 1'b0; base = '0; end
            3'd1: begin gu = gd; gv = gh; au = 2'd2; av = 2'd1; aw = 2'd0;
                su = 1'b0; sv = 1'b1; neg = 1'b1; base = ah_d; end
            3'd2: begin gu = gw; gv = gd; au = 2'd0; av = 2'd2; aw = 2'd1;
                su = 1'b0; sv = 1'b0; neg = 1'b0; base = 19'(2 * ah_d); end
            3'd3: begin gu = gw; gv = gd; au = 2'd0; av = 2'd2; aw = 2'd1;
                su = 1'b0; sv = 1'b1; neg = 1'b1; base = 19'(2 * ah_d + aw_d); end
            3'd4: begin gu = gw; gv = gh; au = 2'd0; av = 2'd1; aw = 2'd2;
                su = 1'b0; sv = 1'b1; neg = 1'b0;
                base = 19'(2 * ah_d + 2 * aw_d); end
            3'd5: begin gu = gw; gv = gh; au = 2'd0; av = 2'd1; aw = 2'd2;
                su = 1'b1; sv = 1'b1; neg = 1'b1;
                base = 19'(2 * ah_d + 2 * aw_d + aw_h); end
            default: bad = 1'b1;
        endcase
        if (operation == OP_VERTEX)
        begin
            if (grid_col > gu || grid_row > gv) bad = 1'b1;
        end
        else
        begin
            if (grid_col >= gu || grid_row >= gv) bad = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid1_reg <= 1'b0;
        else valid1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= operation; bad1_reg <= bad; neg1_reg <= neg;
        su1_reg <= su; sv1_reg <= sv;
        au1_reg <= au; av1_reg <= av; aw1_reg <= aw;
        c1_reg <= grid_col; r1_reg <= grid_row; gu1_reg <= gu; gv1_reg <= gv;
        eu1_reg <= ext(cfg, au); ev1_reg <= ext(cfg, av); ew1_reg <= ext(cfg, aw);
        en1_reg <= ext(cfg, aw) != 16'd0;
        base1_reg <= base;
    end

    // stage 2: numerators |2k-g|*E and corner indices
    logic [9:0] ku, kv;
    logic nu, nv;
    logic [15:0] hw, hw_pos;
    logic [18:0] stride, ia, ib;
    result_t sd;
    logic [31:0] pu, pv;

    always_comb
    begin
        ku = {1'b0, c1_reg, 1'b0} - {2'b0, gu1_reg};
        kv = {1'b0, r1_reg, 1'b0} - {2'b0, gv1_reg};
        nu = ku[9];
        nv = kv[9];
        if (nu) ku = -ku;
        if (nv) kv = -kv;
        pu = {23'd0, ku[8:0]} * {16'd0, eu1_reg};
        pv = {23'd0, kv[8:0]} * {16'd0, ev1_reg};
        hw = 16'(({1'b0, ew1_reg} + 17'd1) >> 1);
        // a half extent of 32768 saturates on the positive side
        hw_pos = hw[15] ? 16'h7fff : hw;
        stride = {11'd0, gu1_reg} + 19'd1;
        ia = base1_reg + {11'd0, c1_reg} + 19'(stride * r1_reg);
        ib = ia + stride;
        sd = '0;
        sd.range_error = bad1_reg;
        if (!bad1_reg && op1_reg == OP_QUAD)
        begin
            sd.corner_a = ia;
            sd.corner_b = ib;
            sd.corner_c = ib + 19'd1;
            sd.corner_d = ia + 19'd1;
        end
        if (!bad1_reg && op1_reg == OP_VERTEX)
        begin
            sd.normal_code = {aw1_reg, 1'b0} + {2'b0, !((!neg1_reg) && en1_reg)};
            // w coordinate lives in pos_x..z, in-plane ones filled later
            unique case (aw1_reg)
                2'd0: sd.pos_x = neg1_reg ? -hw : hw_pos;
                2'd1: sd.pos_y = neg1_reg ? -hw : hw_pos;
                default: sd.pos_z = neg1_reg ? -hw : hw_pos;
            endcase
            // stash axis and sign info in the tex_u field until the end
            sd.tex_u = {11'd0, au1_reg, av1_reg, su1_reg ^ nu, sv1_reg ^ nv};
        end
    end

    logic valid2_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid2_reg <= 1'b0;
        else valid2_reg <= valid1_reg;
    end

    logic [31:0] nu_reg, nv_reg, ntu_reg, ntv_reg;
    logic [15:0] du_reg, dv_reg;
    result_t side_reg;
    logic vtx_reg;
    always_ff @(posedge clk)
    begin
        nu_reg <= pu + {24'd0, gu1_reg};
        nv_reg <= pv + {24'd0, gv1_reg};
        du_reg <= {7'd0, gu1_reg, 1'b0};
        dv_reg <= {7'd0, gv1_reg, 1'b0};
        ntu_reg <= {7'd0, c1_reg, 17'd0} + {24'd0, gu1_reg};
        ntv_reg <= {7'd0, 8'(gv1_reg - r1_reg), 17'd0} + {24'd0, gv1_reg};
        side_reg <= sd;
        vtx_reg <= !bad1_reg && op1_reg == OP_VERTEX;
    end

    assign out_valid = valid2_reg;
    assign num_u = nu_reg;
    assign num_v = nv_reg;
    assign den_u = du_reg;
    assign den_v = dv_reg;
    assign num_tu = ntu_reg;
    assign num_tv = ntv_reg;
    assign tag = {7'd0, vtx_reg};
    assign side = side_reg;
endmodule

// ===== hw/rtl/box_mesh_tessellator.sv =====
`timescale 1ns / 1ps
// Box mesh tessellator: one vertex or quad request may start every cycle; each
// result passes two decode stages, a 33-stage divider pipeline and one output
// stage, and is then on the outputs with done high for one cycle.
// The receiver cannot stall; take each result in the cycle that done is high.
// busy stays low. Write configuration only while no request is in flight.
module box_mesh_tessellator
    import bmt_pkg::*;
#(
    parameter int MAX_SEGMENTS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [2:0]  face,
    input  logic [7:0]  grid_col,
    input  logic [7:0]  grid_row,
    output logic        done,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [15:0] pos_z,
    output logic [2:0]  normal_code,
    output logic [16:0] tex_u,
    output logic [16:0] tex_v,
    output logic [18:0] corner_a,
    output logic [18:0] corner_b,
    output logic [18:0] corner_c,
    output logic [18:0] corner_d,
    output logic        range_error
);
    localparam int DLY = 33;
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{16'd256, 16'd256, 16'd256, 8'd1, 8'd1, 8'd1};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH: cfg_reg.width <= cfg_data;
                CFG_HEIGHT: cfg_reg.height <= cfg_data;
                CFG_DEPTH: cfg_reg.depth <= cfg_data;
                CFG_WSEG: cfg_reg.wseg <= cfg_data[7:0];
                CFG_HSEG: cfg_reg.hseg <= cfg_data[7:0];
                CFG_DSEG: cfg_reg.dseg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cfg_t cfg_eff;
    always_comb
    begin
        cfg_eff = cfg_reg;
        if (32'(cfg_reg.wseg) > MAX_SEGMENTS) cfg_eff.wseg = 8'(MAX_SEGMENTS);
        if (32'(cfg_reg.hseg) > MAX_SEGMENTS) cfg_eff.hseg = 8'(MAX_SEGMENTS);
        if (32'(cfg_reg.dseg) > MAX_SEGMENTS) cfg_eff.dseg = 8'(MAX_SEGMENTS);
    end

    logic fv;
    logic [31:0] nu, nv, ntu, ntv;
    logic [15:0] du, dv;
    logic [7:0] tg;
    result_t sd;

    bmt_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_eff), .in_valid(start && !busy),
        .operation(operation), .face(face), .grid_col(grid_col),
        .grid_row(grid_row), .out_valid(fv), .num_u(nu), .num_v(nv),
        .den_u(du), .den_v(dv), .num_tu(ntu), .num_tv(ntv), .tag(tg), .side(sd)
    );

    logic v0, v1, v2, v3;
    logic [31:0] qu, qv, qtu, qtv;
    logic [7:0] t0, t1, t2, t3;

    bmt_divider u_du (.clk(clk), .rst_n(rst_n), .in_valid(fv), .in_num(nu),
        .in_den(du), .in_tag(tg), .out_valid(v0), .out_quo(qu), .out_tag(t0));
    bmt_divider u_dv (.clk(clk), .rst_n(rst_n), .in_valid(fv), .in_num(nv),
        .in_den(dv), .in_tag(tg), .out_valid(v1), .out_quo(qv), .out_tag(t1));
    bmt_divider u_dtu (.clk(clk), .rst_n(rst_n), .in_valid(fv), .in_num(ntu),
        .in_den(du), .in_tag(tg), .out_valid(v2), .out_quo(qtu), .out_tag(t2));
    bmt_divider u_dtv (.clk(clk), .rst_n(rst_n), .in_valid(fv), .in_num(ntv),
        .in_den(dv), .in_tag(tg), .out_valid(v3), .out_quo(qtv), .out_tag(t3));

    result_t side_dly [DLY];
    always_ff @(posedge clk)
    begin
        side_dly[0] <= sd;
        for (int i = 1; i < DLY; i++) side_dly[i] <= side_dly[i-1];
    end

    result_t sd_at, res;
    logic [1:0] au, av;
    logic nsu, nsv;
    logic signed [33:0] xu, xv;
    logic [15:0] pu, pv;

    function automatic logic [15:0] sat(input logic signed [33:0] x);
        if (x > 34'sd32767) sat = 16'h7fff;
        else if (x < -34'sd32768) sat = 16'h8000;
        else sat = x[15:0];
    endfunction

    always_comb
    begin
        sd_at = side_dly[DLY-1];
        {au, av, nsu, nsv} = sd_at.tex_u[5:0];
        xu = nsu ? -$signed({2'b0, qu}) : $signed({2'b0, qu});
        xv = nsv ? -$signed({2'b0, qv}) : $signed({2'b0, qv});
        pu = sat(xu);
        pv = sat(xv);
        res = sd_at;
        if (t0[0])
        begin
            unique case (au)
                2'd0: res.pos_x = pu;
                2'd1: res.pos_y = pu;
                default: res.pos_z = pu;
            endcase
            unique case (av)
                2'd0: res.pos_x = pv;
                2'd1: res.pos_y = pv;
                default: res.pos_z = pv;
            endcase
            res.tex_u = qtu[16:0];
            res.tex_v = qtv[16:0];
        end
    end

    logic done_reg;
    result_t res_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else done_reg <= v0;
    end
    always_ff @(posedge clk) res_reg <= res;

    assign busy = 1'b0;
    assign done = done_reg;
    assign pos_x = res_reg.pos_x;
    assign pos_y = res_reg.pos_y;
    assign pos_z = res_reg.pos_z;
    assign normal_code = res_reg.normal_code;
    assign tex_u = res_reg.tex_u;
    assign tex_v = res_reg.tex_v;
    assign corner_a = res_reg.corner_a;
    assign corner_b = res_reg.corner_b;
    assign corner_c = res_reg.corner_c;
    assign corner_d = res_reg.corner_d;
    assign range_error = res_reg.range_error;

`ifndef SYNTHESIS
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        v0 == v1 && v1 == v2 && v2 == v3) else $error("divider lanes out of step");
    a_tags: assert property (@(posedge clk) disable iff (!rst_n)
        v0 |-> t0 == t1 && t1 == t2 && t2 == t3) else $error("tag mismatch");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_error |-> corner_a == 19'd0 && tex_u == 17'd0)
        else $error("error result not cleared");
    a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule
